// ----- design/lsf_pkg.sv -----
package lsf_pkg;

  localparam int unsigned MAX_CHARS = 32;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned LEN_W     = 6;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [IDX_W-1:0] REG_CHARS_0_7      = 3'd1;
  localparam logic [IDX_W-1:0] REG_CHARS_8_15     = 3'd2;
  localparam logic [IDX_W-1:0] REG_CHARS_16_23    = 3'd3;
  localparam logic [IDX_W-1:0] REG_CHARS_24_31    = 3'd4;

  typedef struct packed {
    logic [31:0] line_start;
    logic [31:0] line_length;
    logic [31:0] match_total;
  } result_t;

  // Lower-case ASCII letters, carriage return becomes a space.
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] f;
    f = b;
    if (b == CH_CR) begin
      f = CH_SPACE;
    end else if (b >= CH_UP_A && b <= CH_UP_Z) begin
      f = b + CASE_OFS;
    end
    return f;
  endfunction

endpackage

// ----- design/line_substring_filter_top.sv -----
// channel   | valid       | stall       | payload
// text in   | text_valid  | text_stall  | text_byte
// lines out | line_valid  | line_stall  | line_start, line_length, match_total
// config    | cfg_write   | (none)      | cfg_index, cfg_data
//
// One byte per clock while no word waits under line_stall; a matching line's
// word reaches the output via the input register, then the result register.
// The window compare is a single parallel pass over up to 32 positions.
// Reset (rst, synchronous) clears the window, line state, offsets, counter
// and pattern registers. A stalled result holds the byte pipeline; bytes
// stop being taken only while a result word waits under line_stall.
module line_substring_filter_top #(
  parameter int unsigned PATLEN = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_byte,
  output logic        line_valid,
  input  logic        line_stall,
  output logic [31:0] line_start,
  output logic [31:0] line_length,
  output logic [31:0] match_total,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import lsf_pkg::*;

  localparam int unsigned BW = $clog2(PATLEN + 1);

  logic [LEN_W-1:0]                pattern_length;
  logic [MAX_CHARS-1:0][7:0]       pattern;
  logic                            s0_valid;
  logic [7:0]                      s0_byte;
  logic                            advance;
  logic                            step;
  logic                            out_free;
  logic [PATLEN-1:0][7:0]          window_next;
  logic [BW-1:0]                   fill_next;
  logic                            hit;
  logic                            emit;
  result_t                         result;
  result_t                         held;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      pattern        <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length   <= cfg_data[LEN_W-1:0];
        REG_CHARS_0_7:      pattern[7:0]     <= cfg_data;
        REG_CHARS_8_15:     pattern[15:8]    <= cfg_data;
        REG_CHARS_16_23:    pattern[23:16]   <= cfg_data;
        REG_CHARS_24_31:    pattern[31:24]   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance    = out_free;
  assign step       = s0_valid && advance;
  assign text_stall = s0_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (!text_stall) begin
      s0_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      s0_byte <= text_byte;
    end
  end

  lsf_line_track #(.PATLEN(PATLEN), .BW(BW)) u_track (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .raw_byte    (s0_byte),
    .hit         (hit),
    .window_next (window_next),
    .fill_next   (fill_next),
    .emit        (emit),
    .result      (result)
  );

  lsf_matcher #(.PATLEN(PATLEN), .BW(BW)) u_match (
    .window         (window_next),
    .fill           (fill_next),
    .pattern_length (pattern_length),
    .pattern        (pattern),
    .hit            (hit)
  );

  lsf_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (emit),
    .result     (result),
    .line_valid (line_valid),
    .line_stall (line_stall),
    .free       (out_free),
    .held       (held)
  );

  assign line_start  = held.line_start;
  assign line_length = held.line_length;
  assign match_total = held.match_total;

  a_take_fills_stage: assert property (@(posedge clk) disable iff (rst)
    text_valid && !text_stall |=> s0_valid)
    else $error("accepted byte lost before processing");

endmodule

// ----- design/lsf_matcher.sv -----
module lsf_matcher #(
  parameter int unsigned PATLEN = 32,
  parameter int unsigned BW     = 6
) (
  input  logic [PATLEN-1:0][7:0]                         window,
  input  logic [BW-1:0]                                  fill,
  input  logic [lsf_pkg::LEN_W-1:0]                      pattern_length,
  input  logic [lsf_pkg::MAX_CHARS-1:0][7:0]             pattern,
  output logic                                           hit
);
  import lsf_pkg::*;

  localparam int unsigned NCMP = (PATLEN < MAX_CHARS) ? PATLEN : MAX_CHARS;
  localparam int unsigned CW   = 7;
  localparam int unsigned PW   = $clog2(MAX_CHARS);

  logic [NCMP-1:0] char_ok;
  logic            len_ok;

  for (genvar k = 0; k < NCMP; k++) begin : g_cmp
    logic [LEN_W-1:0] pidx;
    assign pidx       = pattern_length - LEN_W'(k) - LEN_W'(1);
    // positions beyond the pattern do not take part
    assign char_ok[k] = (LEN_W'(k) >= pattern_length) ||
                        (window[k] == fold_byte(pattern[pidx[PW-1:0]]));
  end

  assign len_ok = (pattern_length != '0) &&
                  (CW'(pattern_length) <= CW'(PATLEN)) &&
                  (CW'(pattern_length) <= CW'(MAX_CHARS)) &&
                  (CW'(fill) >= CW'(pattern_length));

  assign hit = len_ok && (&char_ok);

endmodule

// ----- design/lsf_line_track.sv -----
module lsf_line_track #(
  parameter int unsigned PATLEN = 32,
  parameter int unsigned BW     = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              raw_byte,
  input  logic                    hit,
  output logic [PATLEN-1:0][7:0]  window_next,
  output logic [BW-1:0]           fill_next,
  output logic                    emit,
  output lsf_pkg::result_t        result
);
  import lsf_pkg::*;

  logic [PATLEN-1:0][7:0] recent_bytes;
  logic [BW-1:0]          bytes_in_line;
  logic                   line_found;
  logic [31:0]            byte_offset;
  logic [31:0]            current_line_start;
  logic [31:0]            match_counter;
  logic [31:0]            match_counter_next;
  logic                   is_lf;

  assign is_lf = (raw_byte == CH_LF);

  always_comb begin
    window_next[0] = fold_byte(raw_byte);
    for (int k = 1; k < PATLEN; k++) begin
      window_next[k] = recent_bytes[k-1];
    end
  end

  assign fill_next = (bytes_in_line == BW'(PATLEN)) ? bytes_in_line
                                                     : bytes_in_line + BW'(1);

  assign match_counter_next = (match_counter == '1) ? match_counter
                                                     : match_counter + 32'd1;

  assign emit               = step && is_lf && line_found;
  assign result.line_start  = current_line_start;
  assign result.line_length = byte_offset - current_line_start;
  assign result.match_total = match_counter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes       <= '0;
      bytes_in_line      <= '0;
      line_found         <= 1'b0;
      byte_offset        <= '0;
      current_line_start <= '0;
      match_counter      <= '0;
    end else if (step) begin
      byte_offset <= byte_offset + 32'd1;
      if (is_lf) begin
        if (line_found) begin
          match_counter <= match_counter_next;
        end
        line_found         <= 1'b0;
        bytes_in_line      <= '0;
        current_line_start <= byte_offset + 32'd1;
      end else begin
        recent_bytes  <= window_next;
        bytes_in_line <= fill_next;
        if (hit) begin
          line_found <= 1'b1;
        end
      end
    end
  end

  a_lf_clears_line: assert property (@(posedge clk) disable iff (rst)
    step && is_lf |=> bytes_in_line == '0 && !line_found)
    else $error("line state not cleared after newline");

  a_counter_monotonic: assert property (@(posedge clk) disable iff (rst)
    step |=> match_counter >= $past(match_counter))
    else $error("match counter went backwards");

endmodule

// ----- design/lsf_out_reg.sv -----
module lsf_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  lsf_pkg::result_t  result,
  output logic              line_valid,
  input  logic              line_stall,
  output logic              free,
  output lsf_pkg::result_t  held
);
  import lsf_pkg::*;

  // a waiting word blocks the next one only while the sink stalls
  assign free = !(line_valid && line_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= 1'b0;
    end else if (load) begin
      line_valid <= 1'b1;
    end else if (!line_stall) begin
      line_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result overwritten while waiting");

endmodule

// ----- verif/lsf_line_checker.sv -----
module lsf_line_checker #(
  parameter int unsigned WIN = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  input  logic        text_stall,
  input  logic [7:0]  text_byte,
  input  logic        line_valid,
  input  logic        line_stall,
  input  logic [31:0] line_start,
  input  logic [31:0] line_length,
  input  logic [31:0] match_total,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          mismatches,
  output int          reports_waiting,
  output int          reports_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import lsf_pkg::*;

  // predicted line state
  logic [7:0]  recent [WIN];
  int unsigned line_fill;
  logic        line_hit;
  logic [31:0] next_ofs;
  logic [31:0] cur_start;
  logic [31:0] hits;

  // shadow of the pattern registers
  logic [LEN_W-1:0] pat_len;
  logic [63:0]      pat_words [4];

  result_t pending_reports [$];
  result_t want;
  int      fail_cnt = 0;
  int      seen_cnt = 0;

  function automatic logic [7:0] lower_byte(input logic [7:0] b);
    if (b == CH_CR) return CH_SPACE;
    if (b >= CH_UP_A && b <= CH_UP_Z) return b + CASE_OFS;
    return b;
  endfunction

  function automatic logic [7:0] pattern_at(input int idx);
    return lower_byte(pat_words[idx / 8][(idx % 8) * 8 +: 8]);
  endfunction

  function automatic logic window_hit();
    int len;
    len = pat_len;
    if (len == 0 || len > WIN || len > MAX_CHARS) return 1'b0;
    if (line_fill < len) return 1'b0;
    for (int k = 0; k < len; k++) begin
      if (recent[k] != pattern_at(len - 1 - k)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void take_text_byte(input logic [7:0] raw);
    logic [31:0] here;
    result_t     r;
    here = next_ofs;
    next_ofs = here + 32'd1;
    if (raw == CH_LF) begin
      if (line_hit) begin
        if (hits != 32'hFFFF_FFFF) hits = hits + 32'd1;
        r.line_start  = cur_start;
        r.line_length = here - cur_start;
        r.match_total = hits;
        pending_reports.push_back(r);
      end
      line_hit  = 1'b0;
      line_fill = 0;
      cur_start = here + 32'd1;
    end else begin
      // shift the folded byte into the window, newest at index 0
      for (int i = WIN - 1; i > 0; i--) recent[i] = recent[i - 1];
      recent[0] = lower_byte(raw);
      if (line_fill < WIN) line_fill++;
      if (!line_hit && window_hit()) line_hit = 1'b1;
    end
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0d got %0d", $time, field, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN; i++) recent[i] = 8'h00;
      line_fill = 0;
      line_hit  = 1'b0;
      next_ofs  = '0;
      cur_start = '0;
      hits      = '0;
      pat_len   = '0;
      for (int w = 0; w < 4; w++) pat_words[w] = '0;
      pending_reports.delete();
    end else begin
      if (line_valid && !line_stall) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: line word with none expected: start %0d length %0d total %0d",
                   $time, line_start, line_length, match_total);
          fail_cnt++;
        end else begin
          want = pending_reports.pop_front();
          compare_field("line_start", want.line_start, line_start);
          compare_field("line_length", want.line_length, line_length);
          compare_field("match_total", want.match_total, match_total);
          seen_cnt++;
        end
      end
      if (text_valid && !text_stall) take_text_byte(text_byte);
      if (cfg_write) begin
        case (cfg_index)
          REG_PATTERN_LENGTH: pat_len = cfg_data[LEN_W-1:0];
          REG_CHARS_0_7:      pat_words[0] = cfg_data;
          REG_CHARS_8_15:     pat_words[1] = cfg_data;
          REG_CHARS_16_23:    pat_words[2] = cfg_data;
          REG_CHARS_24_31:    pat_words[3] = cfg_data;
          default: ;
        endcase
      end
    end
    mismatches      <= fail_cnt;
    reports_waiting <= pending_reports.size();
    reports_seen    <= seen_cnt;
  end

endmodule

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lsf_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam int unsigned WIN_LEN = 32;
  localparam int RANDOM_BYTES = 1450;
  localparam int PHASE_BYTES  = 110;
  localparam logic [IDX_W-1:0] REG_LAST = REG_CHARS_24_31;

  logic        clk;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic        text_stall;
  logic [7:0]  text_byte = 8'h00;
  logic        line_valid;
  logic        line_stall = 1'b0;
  logic [31:0] line_start;
  logic [31:0] line_length;
  logic [31:0] match_total;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  int mismatches;
  int reports_waiting;
  int reports_seen;

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int bytes_sent = 0;
  int settings = 0;

  logic [7:0] pat_bytes [MAX_CHARS];
  logic [7:0] line_buf [$];

  line_substring_filter_top #(.PATLEN(WIN_LEN)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_byte   (text_byte),
    .line_valid  (line_valid),
    .line_stall  (line_stall),
    .line_start  (line_start),
    .line_length (line_length),
    .match_total (match_total),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  lsf_line_checker #(.WIN(WIN_LEN)) u_checker (
    .clk             (clk),
    .rst             (rst),
    .text_valid      (text_valid),
    .text_stall      (text_stall),
    .text_byte       (text_byte),
    .line_valid      (line_valid),
    .line_stall      (line_stall),
    .line_start      (line_start),
    .line_length     (line_length),
    .match_total     (match_total),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .reports_waiting (reports_waiting),
    .reports_seen    (reports_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    line_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_gap_pct = 61;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_gap_pct = 0;
        recv_stall_pct = 61;
      end
      default: begin
        send_gap_pct = 23;
        recv_stall_pct = 23;
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      text_valid <= 1'b0;
      @(posedge clk);
    end
    text_valid <= 1'b1;
    text_byte  <= b;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) send_byte(line_buf[i]);
    line_buf.delete();
  endtask

  // cfg_write is left high; the caller drops it after the last write
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  // hold off until every expected word is out and the pipeline has settled
  task automatic drain_pipe();
    text_valid <= 1'b0;
    @(posedge clk);
    while (reports_waiting != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic load_pattern(input int len);
    logic [63:0] d;
    drain_pipe();
    d = {$urandom, $urandom};
    d[LEN_W-1:0] = len[LEN_W-1:0];
    write_reg(REG_PATTERN_LENGTH, d);
    for (int w = 0; w < 4; w++) begin
      for (int b = 0; b < 8; b++) d[b * 8 +: 8] = pat_bytes[w * 8 + b];
      write_reg(IDX_W'(REG_CHARS_0_7 + w), d);
    end
    // an index past the last register must be dropped
    write_reg(IDX_W'(REG_LAST + $urandom_range(1, 3)), {$urandom, $urandom});
    cfg_write <= 1'b0;
    settings++;
  endtask

  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    if ($urandom_range(99) < 10) return $urandom_range(1) ? CH_SPACE : CH_CR;
    c = CH_UP_A + 8'($urandom_range(3));
    return $urandom_range(1) ? c : c + CASE_OFS;
  endfunction

  function automatic logic [7:0] pick_pattern_char();
    int r;
    r = $urandom_range(99);
    if (r < 70) return CH_UP_A + CASE_OFS + 8'($urandom_range(3));
    if (r < 80) return CH_UP_A + 8'($urandom_range(3));
    if (r < 90) return $urandom_range(1) ? CH_SPACE : CH_CR;
    return 8'($urandom_range(255));
  endfunction

  // any byte that folds to the same character as p
  function automatic logic [7:0] variant_of(input logic [7:0] p);
    if (p >= CH_UP_A + CASE_OFS && p <= CH_UP_Z + CASE_OFS) begin
      return $urandom_range(1) ? p - CASE_OFS : p;
    end
    if (p >= CH_UP_A && p <= CH_UP_Z) return $urandom_range(1) ? p + CASE_OFS : p;
    if (p == CH_SPACE || p == CH_CR) return $urandom_range(1) ? CH_SPACE : CH_CR;
    return p;
  endfunction

  task automatic build_line(input int len, input bit terminate);
    int n;
    int ins;
    ins = (len == 0) ? 3 : ((len > MAX_CHARS) ? MAX_CHARS : len);
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 12);
      repeat (n) line_buf.push_back(8'($urandom_range(255)));
    end else begin
      n = ($urandom_range(9) == 0) ? $urandom_range(28, 45) : $urandom_range(0, 6);
      repeat (n) line_buf.push_back(filler_char());
      if ($urandom_range(99) < 60) begin
        for (int k = 0; k < ins; k++) line_buf.push_back(variant_of(pat_bytes[k]));
      end
      n = $urandom_range(0, 6);
      repeat (n) line_buf.push_back(filler_char());
    end
    if (terminate) line_buf.push_back(CH_LF);
  endtask

  initial begin
    int len;
    int phase;
    int stop_at;
    int target;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_idling(IDLE_NONE);

    // empty pattern after reset matches nothing, not even a zero byte
    send_byte(8'h00);
    send_byte("x");
    send_byte(CH_LF);

    // folded pattern with a carriage return and a zero byte
    for (int i = 0; i < MAX_CHARS; i++) pat_bytes[i] = 8'($urandom_range(255));
    pat_bytes[0] = "A";
    pat_bytes[1] = CH_CR;
    pat_bytes[2] = 8'h00;
    load_pattern(3);
    send_byte(8'hFF);
    send_byte("a");
    send_byte(CH_SPACE);
    send_byte(8'h00);
    send_byte(CH_LF);
    send_byte("A");
    send_byte(CH_CR);
    send_byte(8'h00);
    send_byte(CH_LF);

    // a newline inside the pattern can never match
    pat_bytes[0] = "a";
    pat_bytes[1] = CH_LF;
    pat_bytes[2] = "b";
    load_pattern(3);
    send_byte("a");
    send_byte(CH_LF);
    send_byte("b");
    send_byte(CH_LF);

    // lengths past the window match nothing
    for (int i = 0; i < MAX_CHARS; i++) pat_bytes[i] = "a";
    load_pattern(MAX_CHARS + 1);
    send_byte("a");
    send_byte("a");
    send_byte("a");
    send_byte(CH_LF);
    load_pattern(63);
    send_byte("a");
    send_byte(CH_LF);

    phase = 0;
    len = 1;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      if (phase == 1) len = MAX_CHARS;
      else if (phase == 3) len = 0;
      else if (phase == 5) len = $urandom_range(MAX_CHARS + 1, 63);
      else if (phase == 7) len = 1;
      else len = $urandom_range(1, 8);
      for (int i = 0; i < MAX_CHARS; i++) pat_bytes[i] = pick_pattern_char();
      load_pattern(len);
      set_idling(idle_mode_t'(phase % 4));
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        build_line(len, 1'b1);
        send_line();
      end
      phase++;
    end

    // last line without a newline stays unreported
    build_line(len, 1'b0);
    send_line();
    drain_pipe();

    $display("Covered %0d text bytes over %0d pattern settings, %0d line words compared",
             bytes_sent, settings, reports_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/lsf_pkg.sv
design/lsf_matcher.sv
design/lsf_line_track.sv
design/lsf_out_reg.sv
design/line_substring_filter_top.sv
verif/lsf_line_checker.sv
verif/testbench.sv
